FILE: rtl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types and field widths for the TLS slot allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int CMD_W      = 2;
    localparam int SLOT_FLD_W = 8;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 6;

    // slave side: tdata = {write_value, slot}, 40 bits; tuser = cmd
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = CMD_W;
    // master side: tdata = {read_value, slot_index, ok}, padded to 40 bits
    localparam int M_TDATA_W  = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_GET   = 2'd2,
        CMD_SET   = 2'd3
    } t_cmd;

endpackage

FILE: rtl/tls_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// tls_slot_allocator_core
// Bitmap slot allocator: allocate lowest free slot, free, get and set of a
// 32-bit value per slot.
//
//  channel   dir  tdata (low bit up)                     tuser  tlast
//  s_axis    in   slot[7:0], write_value[39:8]           cmd    -
//  m_axis    out  ok[0], slot_index[6:1], read_value[38:7] -    -
//
//  One transaction per cycle sustained while the sink keeps tready high; input
//  register with value-RAM read, then decode/update into the output register.
//  The value RAM's single read port sets the first stage.
//  Synchronous active-low reset clears in-use and value-valid bits at once
//  and holds tready low; no clearing pass. A stalled output holds the item
//  in the input stage and upstream stalls only once both stages are full.
// ----------------------------------------------------------------------------
module tls_slot_allocator_core
    import tsa_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // slot[7:0], write_value[39:8]
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,  // cmd[1:0]
    // master side
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata   // ok[0], slot_index[6:1], read_value[38:7], 0
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // input stage
    logic                  r_a_valid;
    t_cmd                  r_cmd;
    logic [SLOT_FLD_W-1:0] r_slot;
    logic [VALUE_W-1:0]    r_wval;

    // slot state
    logic [SLOTS-1:0]      r_in_use;
    logic [SLOTS-1:0]      r_val_ok;
    logic [SLOTS-1:0]      n_in_use;
    logic [SLOTS-1:0]      n_val_ok;

    // output stage
    logic                  r_out_valid;
    logic                  r_ok;
    logic [INDEX_W-1:0]    r_index;
    logic [VALUE_W-1:0]    r_rval;
    logic                  n_ok;
    logic [INDEX_W-1:0]    n_index;
    logic [VALUE_W-1:0]    n_rval;

    logic                  s_fire;
    logic                  a_adv;
    logic                  in_range_s;
    logic                  in_range_a;
    logic [SLOT_W-1:0]     idx_a;
    logic [SLOT_W-1:0]     rd_addr;
    logic [VALUE_W-1:0]    rd_data;
    logic                  wr_en;
    logic                  any_free;
    logic [SLOT_W-1:0]     grant;
    logic [8:0]            grant_ext;

    assign a_adv           = r_a_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = i_rst_n && (!r_a_valid || a_adv);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    assign in_range_s = {1'b0, i_s_axis_tdata[SLOT_FLD_W-1:0]} < 9'(SLOTS);
    assign rd_addr    = in_range_s ? i_s_axis_tdata[SLOT_W-1:0] : '0;

    assign in_range_a = {1'b0, r_slot} < 9'(SLOTS);
    assign idx_a      = r_slot[SLOT_W-1:0];
    assign wr_en      = a_adv && (r_cmd == CMD_SET) && in_range_a;

    tsa_value_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (idx_a),
        .i_wr_data (r_wval),
        .i_rd_en   (s_fire),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tsa_alloc_enc #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_enc (
        .i_in_use   (r_in_use),
        .o_any_free (any_free),
        .o_grant    (grant)
    );

    assign grant_ext = 9'(grant);

    // decode and state update for the item in the input stage
    always_comb begin
        n_in_use = r_in_use;
        n_val_ok = r_val_ok;
        n_ok     = 1'b0;
        n_index  = '0;
        n_rval   = '0;
        case (r_cmd)
            CMD_ALLOC: begin
                if (any_free) begin
                    n_in_use[grant] = 1'b1;
                    // invalid entry reads as zero: clears the value
                    n_val_ok[grant] = 1'b0;
                    n_ok            = 1'b1;
                    n_index         = grant_ext[INDEX_W-1:0];
                end
            end
            CMD_FREE: begin
                if (in_range_a && r_in_use[idx_a]) begin
                    n_in_use[idx_a] = 1'b0;
                    n_ok            = 1'b1;
                end
            end
            CMD_GET: begin
                if (in_range_a) begin
                    n_ok   = 1'b1;
                    n_rval = r_val_ok[idx_a] ? rd_data : '0;
                end
            end
            CMD_SET: begin
                if (in_range_a) begin
                    n_val_ok[idx_a] = 1'b1;
                    n_ok            = 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_use    <= '0;
            r_val_ok    <= '0;
        end else begin
            if (s_fire) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_out_valid <= 1'b1;
                r_in_use    <= n_in_use;
                r_val_ok    <= n_val_ok;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_cmd  <= t_cmd'(i_s_axis_tuser);
            r_slot <= i_s_axis_tdata[SLOT_FLD_W-1:0];
            r_wval <= i_s_axis_tdata[SLOT_FLD_W +: VALUE_W];
        end
        if (a_adv) begin
            r_ok    <= n_ok;
            r_index <= n_index;
            r_rval  <= n_rval;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - 1 - INDEX_W - VALUE_W)'(0), r_rval, r_index, r_ok};

    // slot state only moves when a transaction leaves the input stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !a_adv |=> $stable(r_in_use) && $stable(r_val_ok))
        else $error("slot state changed without a transaction");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (in_range_a && r_a_valid))
        else $error("value write outside slot range");

    a_alloc_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_adv && (r_cmd == CMD_ALLOC) && any_free) |-> !r_in_use[grant])
        else $error("allocate granted a slot in use");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_a_valid))
        else $error("result without a pending transaction");

endmodule

FILE: rtl/tsa_value_ram.sv
// ----------------------------------------------------------------------------
// tsa_value_ram
// Slot value store: one write port, one registered read port, write-first
// on an address collision so a read sees the value written at the same edge.
// ----------------------------------------------------------------------------
module tsa_value_ram
    import tsa_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_W-1:0]  i_wr_addr,
    input  logic [VALUE_W-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic [VALUE_W-1:0] o_rd_data
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/tsa_alloc_enc.sv
// ----------------------------------------------------------------------------
// tsa_alloc_enc
// First-free search: lowest slot whose in-use bit is clear.
// ----------------------------------------------------------------------------
module tsa_alloc_enc
    import tsa_pkg::*;
#(
    parameter int SLOTS  = 64,
    parameter int SLOT_W = 6
) (
    input  logic [SLOTS-1:0]  i_in_use,
    output logic              o_any_free,
    output logic [SLOT_W-1:0] o_grant
);

    always_comb begin
        o_any_free = 1'b0;
        o_grant    = '0;
        // scan downwards so the lowest free slot wins
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!i_in_use[i]) begin
                o_any_free = 1'b1;
                o_grant    = SLOT_W'(i);
            end
        end
    end

endmodule

FILE: sim/tls_slot_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tls_slot_allocator_core_tb
// Self-checking bench for the slot allocator. Commands go in on the slave
// stream, and a shadow copy of the in-use bitmap and value store predicts
// each result. Results are compared field by field in arrival order. The
// stimulus is a directed opening followed by random blocks that fill, drain
// and mix the slot bank, run under several patterns of source gaps and sink
// stalls, with one long sink hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tls_slot_allocator_core_tb;
    import tsa_pkg::*;

    localparam int NUM_SLOTS    = 64;
    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic               ok;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } t_slot_result;

    typedef enum int {MIX_EXHAUST, MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // shadow of the slot bank plus the queue of results still owed
    class slot_bank_board;
        bit                 in_use[NUM_SLOTS];
        logic [VALUE_W-1:0] values[NUM_SLOTS];
        t_slot_result       owed[$];
        int                 mismatches;

        function new();
            foreach (in_use[i]) begin
                in_use[i] = 1'b0;
                values[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void note_command(t_cmd cmd, logic [SLOT_FLD_W-1:0] slot,
                                   logic [VALUE_W-1:0] wval);
            t_slot_result r;
            bit           in_range;
            r.ok     = 1'b0;
            r.index  = '0;
            r.value  = '0;
            in_range = slot < NUM_SLOTS;
            case (cmd)
                CMD_ALLOC: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!in_use[i]) begin
                            in_use[i] = 1'b1;
                            values[i] = '0;
                            r.index   = INDEX_W'(i);
                            r.ok      = 1'b1;
                            break;
                        end
                    end
                end
                CMD_FREE: begin
                    if (in_range && in_use[slot]) begin
                        in_use[slot] = 1'b0;
                        r.ok         = 1'b1;
                    end
                end
                CMD_GET: begin
                    if (in_range) begin
                        r.value = values[slot];
                        r.ok    = 1'b1;
                    end
                end
                CMD_SET: begin
                    if (in_range) begin
                        values[slot] = wval;
                        r.ok         = 1'b1;
                    end
                end
            endcase
            owed.push_back(r);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            t_slot_result       exp;
            logic               ok;
            logic [INDEX_W-1:0] idx;
            logic [VALUE_W-1:0] val;
            ok  = tdata[0];
            idx = tdata[INDEX_W:1];
            val = tdata[INDEX_W+VALUE_W:INDEX_W+1];
            if (owed.size() == 0) begin
                report($sformatf("result with nothing owed: ok=%0b index=%0d value=%h",
                                 ok, idx, val));
                return;
            end
            exp = owed.pop_front();
            if (ok !== exp.ok || idx !== exp.index || val !== exp.value)
                report($sformatf("result mismatch: exp ok=%0b index=%0d value=%h, got ok=%0b index=%0d value=%h",
                                 exp.ok, exp.index, exp.value, ok, idx, val));
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        function int used_count();
            int c;
            c = 0;
            foreach (in_use[i])
                if (in_use[i])
                    c++;
            return c;
        endfunction

        // k-th used slot, counting from zero
        function logic [SLOT_FLD_W-1:0] nth_used(int k);
            foreach (in_use[i]) begin
                if (in_use[i]) begin
                    if (k == 0)
                        return SLOT_FLD_W'(i);
                    k--;
                end
            end
            return '0;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;   // slot[7:0], write_value[39:8]
    logic [S_TUSER_W-1:0] i_s_axis_tuser;   // cmd[1:0]
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;   // ok[0], slot_index[6:1], read_value[38:7]

    slot_bank_board board = new();

    int idle_pct     = 0;
    int stall_pct    = 0;
    int accepted_cnt = 0;
    int cycle_cnt    = 0;
    int hold_left    = 0;
    bit hold_started = 1'b0;

    tls_slot_allocator_core #(
        .SLOTS(NUM_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_ALLOC;
        i_m_axis_tready = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // transaction monitors on both streams
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                board.note_command(t_cmd'(i_s_axis_tuser), i_s_axis_tdata[SLOT_FLD_W-1:0],
                                   i_s_axis_tdata[SLOT_FLD_W+VALUE_W-1:SLOT_FLD_W]);
                accepted_cnt++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_result(o_m_axis_tdata);
        end
    end

    // sink: random stalls, plus one long hold-off early on to fill the pipe
    always @(negedge i_clk) begin
        if (!hold_started && accepted_cnt >= 100) begin
            hold_left    = HOLD_CYCLES;
            hold_started = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_cmd(t_cmd cmd, logic [SLOT_FLD_W-1:0] slot, logic [VALUE_W-1:0] wval);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {wval, slot};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly slots in use, some free ones, some out of range
    function automatic logic [SLOT_FLD_W-1:0] pick_slot();
        int r;
        int used;
        r    = $urandom_range(99);
        used = board.used_count();
        if (r < 55 && used > 0)
            return board.nth_used($urandom_range(used - 1));
        if (r < 80)
            return SLOT_FLD_W'($urandom_range(NUM_SLOTS - 1));
        if (r < 95)
            return SLOT_FLD_W'($urandom_range(255, NUM_SLOTS));
        case ($urandom_range(3))
            0:       return '0;
            1:       return SLOT_FLD_W'(NUM_SLOTS - 1);
            2:       return SLOT_FLD_W'(NUM_SLOTS);
            default: return '1;
        endcase
    endfunction

    function automatic t_cmd pick_cmd(t_mix mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL:  return r < 50 ? CMD_ALLOC : r < 70 ? CMD_SET : r < 90 ? CMD_GET : CMD_FREE;
            MIX_DRAIN: return r < 60 ? CMD_FREE : r < 75 ? CMD_GET : r < 90 ? CMD_SET : CMD_ALLOC;
            default:   return t_cmd'(r % 4);
        endcase
    endfunction

    initial begin
        int   n;
        int   span;
        int   ph;
        t_mix mix;
        int   idle_tab[4]  = '{0, 53, 0, 8};
        int   stall_tab[4] = '{0, 0, 53, 8};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: range edges, unused slots, reuse and clearing on allocate
        send_cmd(CMD_GET,   8'd0,   '0);
        send_cmd(CMD_GET,   8'd63,  '0);
        send_cmd(CMD_GET,   8'd64,  '1);
        send_cmd(CMD_GET,   8'd255, '1);
        send_cmd(CMD_SET,   8'd255, '1);
        send_cmd(CMD_SET,   8'd64,  32'h1234_5678);
        send_cmd(CMD_FREE,  8'd0,   '0);
        send_cmd(CMD_FREE,  8'd63,  '0);
        send_cmd(CMD_FREE,  8'd255, '1);
        send_cmd(CMD_SET,   8'd5,   '1);
        send_cmd(CMD_GET,   8'd5,   '0);
        send_cmd(CMD_ALLOC, 8'd255, '1);
        send_cmd(CMD_ALLOC, 8'd0,   '0);
        send_cmd(CMD_SET,   8'd0,   '1);
        send_cmd(CMD_GET,   8'd0,   '0);
        send_cmd(CMD_FREE,  8'd0,   '0);
        send_cmd(CMD_FREE,  8'd0,   '0);
        send_cmd(CMD_ALLOC, 8'd17,  32'hdead_beef);
        send_cmd(CMD_GET,   8'd0,   '0);
        send_cmd(CMD_SET,   8'd63,  '0);
        send_cmd(CMD_GET,   8'd63,  '1);
        send_cmd(CMD_FREE,  8'd1,   '0);
        send_cmd(CMD_FREE,  8'd200, '0);

        n = 0;
        while (n < RANDOM_ITEMS) begin
            ph        = (n * 4) / RANDOM_ITEMS;
            idle_pct  = idle_tab[ph];
            stall_pct = stall_tab[ph];
            mix       = t_mix'($urandom_range(3));
            if (mix == MIX_EXHAUST) begin
                // run the bank dry, then a few allocates that must fail
                span = NUM_SLOTS - board.used_count() + $urandom_range(1, 4);
                repeat (span) begin
                    send_cmd(CMD_ALLOC, SLOT_FLD_W'($urandom), rand_value());
                    n++;
                end
            end else begin
                span = $urandom_range(20, 40);
                repeat (span) begin
                    send_cmd(pick_cmd(mix), pick_slot(), rand_value());
                    n++;
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
